// File: sv/gba_pkg.sv
// Shared types, codes and a helper function of the grouped bitmap allocator.
package gba_pkg;

  // Operation codes of an input item. The remaining code is a no-op.
  typedef enum logic [1:0] {
    OP_LOAD_BYTE  = 2'd0,
    OP_LOAD_COUNT = 2'd1,
    OP_ALLOC      = 2'd2
  } gba_op_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_UNITS_PER_GROUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT     = 2'd1;

  localparam int unsigned COUNT_W = 14;
  localparam int unsigned UNIT_W  = 17;
  localparam logic [7:0]  FULL_BYTE = 8'hFF;

  localparam logic [COUNT_W-1:0] UNITS_RESET  = 14'd8192;
  localparam logic [3:0]         GROUPS_RESET = 4'd8;

  // Control flags from the sequencer to the storage and result logic.
  typedef struct packed {
    logic busy;
    logic bm_re;
    logic cnt_re;
    logic done;
    logic found;
  } gba_ctl_t;

  // Position of the lowest clear bit of a byte, LSB first.
  function automatic logic [2:0] lowest_clear(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

// File: sv/gba_seq.sv
// Allocate sequencer: walks group counts and bitmap bytes through the read ports of the stores.
module gba_seq
  import gba_pkg::*;
#(
  parameter int unsigned GROUPS          = 8,
  parameter int unsigned BYTES_PER_GROUP = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  empty_i,
  input  logic [$clog2(GROUPS+1)-1:0]           grp_lim_i,
  input  logic [$clog2(BYTES_PER_GROUP+1)-1:0]  byte_lim_i,
  input  logic [COUNT_W-1:0]                    units_i,
  input  logic [COUNT_W-1:0]                    cnt_rdata_i,
  input  logic [7:0]                            bm_rdata_i,
  input  logic                                  out_free_i,
  output gba_ctl_t                              ctl_o,
  output logic [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0]                   grp_o,
  output logic [((BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1)-1:0] byte_rd_o,
  output logic [((BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1)-1:0] hit_byte_o,
  output logic [$clog2(GROUPS+1)-1:0]           grp_cnt_o,
  output logic [2:0]                            hit_bit_o,
  output logic [7:0]                            new_byte_o,
  output logic [COUNT_W-1:0]                    new_cnt_o,
  output logic [UNIT_W-1:0]                     unit_o
);

  localparam int unsigned GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned GCW = $clog2(GROUPS + 1);
  localparam int unsigned BW  = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;
  localparam int unsigned BCW = $clog2(BYTES_PER_GROUP + 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CNT_RD  = 5'b00010,
    S_CNT_CHK = 5'b00100,
    S_SCAN    = 5'b01000,
    S_FINISH  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [GCW-1:0]   grp_q, grp_d;
  logic [GCW-1:0]   grp_nxt;
  logic [UNIT_W-1:0] base_q, base_d;
  logic [BCW-1:0]   iss_q, iss_d;
  logic [BW-1:0]    tb_q, tb_d;
  logic             pend_q, pend_d;
  logic             found_q, found_d;
  logic             last_grp;

  assign grp_nxt  = grp_q + 1'b1;
  assign last_grp = (grp_nxt >= grp_lim_i);

  always_comb begin
    state_d = state_q;
    grp_d   = grp_q;
    base_d  = base_q;
    iss_d   = iss_q;
    tb_d    = tb_q;
    pend_d  = pend_q;
    found_d = found_q;
    ctl_o   = '0;
    ctl_o.busy = (state_q != S_IDLE);
    byte_rd_o  = iss_q[BW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          grp_d   = '0;
          base_d  = '0;
          found_d = 1'b0;
          state_d = empty_i ? S_FINISH : S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        ctl_o.cnt_re = 1'b1;
        state_d      = S_CNT_CHK;
      end
      S_CNT_CHK: begin
        if (cnt_rdata_i == '0) begin
          if (last_grp) begin
            state_d = S_FINISH;
          end else begin
            grp_d   = grp_nxt;
            base_d  = base_q + UNIT_W'(units_i);
            state_d = S_CNT_RD;
          end
        end else begin
          iss_d   = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // The byte read last cycle is tested while the next one is fetched.
        if (pend_q && (bm_rdata_i != FULL_BYTE)) begin
          found_d = 1'b1;
          state_d = S_FINISH;
        end else if (iss_q < byte_lim_i) begin
          ctl_o.bm_re = 1'b1;
          tb_d        = iss_q[BW-1:0];
          iss_d       = iss_q + 1'b1;
          pend_d      = 1'b1;
        end else if (last_grp) begin
          state_d = S_FINISH;
        end else begin
          grp_d   = grp_nxt;
          base_d  = base_q + UNIT_W'(units_i);
          state_d = S_CNT_RD;
        end
      end
      S_FINISH: begin
        ctl_o.done  = 1'b1;
        ctl_o.found = found_q;
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    base_q <= base_d;
    iss_q  <= iss_d;
    tb_q   <= tb_d;
  end

  assign grp_o      = grp_q[GW-1:0];
  assign grp_cnt_o  = grp_q;
  assign hit_byte_o = tb_q;
  assign hit_bit_o  = lowest_clear(bm_rdata_i);
  assign new_byte_o = bm_rdata_i | (8'd1 << hit_bit_o);
  assign new_cnt_o  = cnt_rdata_i - 1'b1;
  assign unit_o     = base_q + UNIT_W'({tb_q, 3'b000}) + UNIT_W'(hit_bit_o) + 1'b1;

endmodule

// File: sv/grouped_bitmap_allocator_top.sv
// Top level of the grouped first-fit bitmap allocator with its stores and result register.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i / in_stall_o operation, group_index, byte_index, load_value
//   out      from block out_valid_o / out_stall_i found, unit/group/byte/bit numbers
//   cfg      to block   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Loads and no-op items leave an all-zero result.
// An allocate item reads and checks the free count of each group visited, then reads
// the bitmap bytes of a group with free units one at a time through the single read port
// of the bitmap memory, and at last writes back the claim and posts the result.
// Reset clears control state only; both stores hold nothing defined until loaded.
// A stalled result holds the output register, and no new item is taken until it leaves.
module grouped_bitmap_allocator_top
  import gba_pkg::*;
#(
  parameter int unsigned GROUPS          = 8,
  parameter int unsigned BYTES_PER_GROUP = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic [2:0]           group_index_i,
  input  logic [9:0]           byte_index_i,
  input  logic [13:0]          load_value_i,
  // Result items.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o,
  output logic [16:0]          unit_number_o,
  output logic [3:0]           group_number_o,
  output logic [10:0]          byte_number_o,
  output logic [3:0]           bit_number_o,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COUNT_W-1:0]   cfg_data_i
);

  localparam int unsigned GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned GCW = $clog2(GROUPS + 1);
  localparam int unsigned BW  = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;
  localparam int unsigned BCW = $clog2(BYTES_PER_GROUP + 1);
  localparam int unsigned AW  = GW + BW;

  // Configuration registers. Writes must arrive only while the block is idle; not enforced.
  logic [COUNT_W-1:0] units_q;
  logic [3:0]         groups_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q  <= UNITS_RESET;
      groups_q <= GROUPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_UNITS_PER_GROUP) units_q  <= cfg_data_i;
      if (cfg_index_i == REG_GROUP_COUNT)     groups_q <= cfg_data_i[3:0];
    end
  end

  // Scan geometry, saturated to the sizes of the stores.
  logic [GCW-1:0] grp_lim;
  logic [BCW-1:0] byte_lim;
  logic           empty_geom;

  always_comb begin
    if (int'(groups_q) > GROUPS) grp_lim = GCW'(GROUPS);
    else                         grp_lim = GCW'(groups_q);
    if (int'(units_q[13:3]) > BYTES_PER_GROUP) byte_lim = BCW'(BYTES_PER_GROUP);
    else                                       byte_lim = BCW'(units_q[13:3]);
    empty_geom = (grp_lim == '0) || (byte_lim == '0);
  end

  // Handshakes. The output register is free when empty or being taken this cycle.
  gba_ctl_t ctl;
  logic     out_valid_q;
  logic     out_free;
  logic     in_acc;
  logic     grp_ok;
  logic     byte_ok;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = ctl.busy || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign grp_ok     = int'(group_index_i) < GROUPS;
  assign byte_ok    = int'(byte_index_i) < BYTES_PER_GROUP;

  logic start_alloc;
  logic load_byte;
  logic load_cnt;
  logic claim;

  assign start_alloc = in_acc && (operation_i == OP_ALLOC);
  assign load_byte   = in_acc && (operation_i == OP_LOAD_BYTE) && grp_ok && byte_ok;
  assign load_cnt    = in_acc && (operation_i == OP_LOAD_COUNT) && grp_ok;
  assign claim       = ctl.done && ctl.found && out_free;

  // Sequencer outputs.
  logic [GW-1:0]      seq_grp;
  logic [GCW-1:0]     seq_grp_cnt;
  logic [BW-1:0]      seq_byte_rd;
  logic [BW-1:0]      seq_hit_byte;
  logic [2:0]         seq_hit_bit;
  logic [7:0]         seq_new_byte;
  logic [COUNT_W-1:0] seq_new_cnt;
  logic [UNIT_W-1:0]  seq_unit;
  logic [COUNT_W-1:0] cnt_rdata_q;
  logic [7:0]         bm_rdata_q;

  gba_seq #(
    .GROUPS          (GROUPS),
    .BYTES_PER_GROUP (BYTES_PER_GROUP)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_alloc),
    .empty_i     (empty_geom),
    .grp_lim_i   (grp_lim),
    .byte_lim_i  (byte_lim),
    .units_i     (units_q),
    .cnt_rdata_i (cnt_rdata_q),
    .bm_rdata_i  (bm_rdata_q),
    .out_free_i  (out_free),
    .ctl_o       (ctl),
    .grp_o       (seq_grp),
    .byte_rd_o   (seq_byte_rd),
    .hit_byte_o  (seq_hit_byte),
    .grp_cnt_o   (seq_grp_cnt),
    .hit_bit_o   (seq_hit_bit),
    .new_byte_o  (seq_new_byte),
    .new_cnt_o   (seq_new_cnt),
    .unit_o      (seq_unit)
  );

  // Bitmap memory: one write port shared by loads and claims, one registered read port.
  logic [7:0]    bm_mem [2**AW];
  logic          bm_we;
  logic [AW-1:0] bm_waddr;
  logic [7:0]    bm_wdata;

  always_comb begin
    bm_we    = load_byte || claim;
    bm_waddr = {seq_grp, seq_hit_byte};
    bm_wdata = seq_new_byte;
    if (load_byte) begin
      bm_waddr = {GW'(group_index_i), BW'(byte_index_i)};
      bm_wdata = load_value_i[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (ctl.bm_re) bm_rdata_q <= bm_mem[{seq_grp, seq_byte_rd}];
  end

  // Group free count memory, organized the same way.
  logic [COUNT_W-1:0] cnt_mem [2**GW];
  logic               cnt_we;
  logic [GW-1:0]      cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;

  always_comb begin
    cnt_we    = load_cnt || claim;
    cnt_waddr = seq_grp;
    cnt_wdata = seq_new_cnt;
    if (load_cnt) begin
      cnt_waddr = GW'(group_index_i);
      cnt_wdata = load_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (ctl.cnt_re) cnt_rdata_q <= cnt_mem[seq_grp];
  end

  // Result register. Loads and no-ops post zeros at once; an allocate posts when done.
  logic               out_valid_d;
  logic               found_q;
  logic [UNIT_W-1:0]  unit_q;
  logic [3:0]         group_q;
  logic [10:0]        byte_q;
  logic [3:0]         bit_q;
  logic [GCW:0]       grp_inc;
  logic [BW:0]        byte_inc;

  assign grp_inc  = {1'b0, seq_grp_cnt} + 1'b1;
  assign byte_inc = {1'b0, seq_hit_byte} + 1'b1;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_free && ((in_acc && !start_alloc) || ctl.done)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && ((in_acc && !start_alloc) || ctl.done)) begin
      if (claim) begin
        found_q <= 1'b1;
        unit_q  <= seq_unit;
        group_q <= 4'(grp_inc);
        byte_q  <= 11'(byte_inc);
        bit_q   <= 4'(seq_hit_bit) + 4'd1;
      end else begin
        found_q <= 1'b0;
        unit_q  <= '0;
        group_q <= '0;
        byte_q  <= '0;
        bit_q   <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign unit_number_o  = unit_q;
  assign group_number_o = group_q;
  assign byte_number_o  = byte_q;
  assign bit_number_o   = bit_q;

endmodule
